// ===== rtl/bmf_pkg.sv =====
// Shared types and constants of the clipped-window box mean filter.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package bmf_pkg;
    localparam int PIX_W      = 8;
    localparam int POS_W      = 10;
    localparam int WS_W       = 4;
    localparam int RAD_W      = 3;
    localparam int DIM_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [WS_W-1:0]  WS_RESET  = 4'd3;
    localparam logic [DIM_W-1:0] DIM_RESET = 11'd512;
    localparam logic [PIX_W-1:0] PIX_MAX   = 8'd255;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_SUM,
        S_DIV,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

// ===== rtl/bmf_if.sv =====
// Valid/ready channel interfaces: pixel input beats and smoothed result beats.
// Uses bmf_pkg for field widths.
`default_nettype none
interface bmf_pix_if;
    import bmf_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

interface bmf_res_if;
    import bmf_pkg::*;
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic [PIX_W-1:0] mean_red;
    logic [PIX_W-1:0] mean_green;
    logic [PIX_W-1:0] mean_blue;
    logic             last;
    modport source (output valid, out_row, out_col, mean_red, mean_green, mean_blue, last,
                    input ready);
    modport sink   (input valid, out_row, out_col, mean_red, mean_green, mean_blue, last,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/box_mean_filter_clipped_window_unit.sv =====
// Top level of the clipped-window box mean filter; uses bmf_pkg and bmf_if.
// Row store is one synchronous single-port-write, one-read memory in this module.
// Flow: a pixel that completes no window is stored and the block stays idle. Each
//   result passes through setup, row store reads with summing, bit-serial divide
//   and output; the row store read port (one pixel per cycle) and the bit-serial
//   divider set the pace. One pixel is in flight at a time.
// Reset (synchronous, active low): registers 3/512/512, position (0,0), idle.
//   The row store is not cleared; the filter only reads rows of the current frame.
`default_nettype none
module box_mean_filter_clipped_window_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_WINDOW = 15
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire [bmf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [bmf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    bmf_pix_if.sink                        i_pix,
    bmf_res_if.source                      o_res
);
    import bmf_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int SW    = $clog2(MAX_WINDOW);
    localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW0   = (RW > CW) ? RW : CW;
    localparam int LW    = (LW0 + 2 > DIM_W + 1) ? LW0 + 2 : DIM_W + 1;
    localparam int SUM_W = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
    localparam int CNT_W = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int BIT_W = $clog2(SUM_W + 1);
    localparam int PXW   = 3 * PIX_W;

    // Configuration registers.
    logic [WS_W-1:0]  r_ws;
    logic [DIM_W-1:0] r_cw, r_ch;

    // Input position and its row store slot.
    logic [RW-1:0] r_in_row;
    logic [CW-1:0] r_in_col;
    logic [SW-1:0] r_in_slot;

    t_state r_state, n_state;

    logic [LW-1:0] r_r, r_rhi, r_c, r_clo, r_chi;
    logic [LW-1:0] r_y, r_y1, r_x, r_x0, r_x1;
    logic [CNT_W-1:0] r_cnt;
    logic             r_iss_done, r_rd_vld;
    logic [PXW-1:0]   r_rd_data;
    logic [SUM_W-1:0] r_sum [3];
    logic [SUM_W-1:0] r_rem [3];
    logic [SUM_W-1:0] r_quo [3];
    logic [BIT_W-1:0] r_bit;
    logic [PIX_W-1:0] r_mean [3];
    logic             r_last;

    logic [PXW-1:0] mem [DEPTH];

    // Effective geometry.
    logic [LW-1:0] w_eff, h_eff, m;
    always_comb begin
        if (r_cw == '0)                     w_eff = LW'(1);
        else if (LW'(r_cw) > LW'(MAX_WIDTH)) w_eff = LW'(MAX_WIDTH);
        else                                w_eff = LW'(r_cw);
        if (r_ch == '0)                      h_eff = LW'(1);
        else if (LW'(r_ch) > LW'(MAX_HEIGHT)) h_eff = LW'(MAX_HEIGHT);
        else                                 h_eff = LW'(r_ch);
        m = (r_ws == '0) ? '0 : LW'((r_ws - 4'd1) >> 1);
    end

    // Which results the incoming pixel completes.
    logic [LW-1:0] ir, ic, rlo, rhi, clo, chi;
    logic          have_r, have_c, row_end, col_end;
    always_comb begin
        ir      = LW'(r_in_row);
        ic      = LW'(r_in_col);
        row_end = (ir == h_eff - LW'(1));
        col_end = (ic == w_eff - LW'(1));
        rlo     = (ir >= m) ? ir - m : '0;
        clo     = (ic >= m) ? ic - m : '0;
        rhi     = row_end ? ir : rlo;
        chi     = col_end ? ic : clo;
        have_r  = row_end || (ir >= m);
        have_c  = col_end || (ic >= m);
    end

    // Window bounds of the result being set up.
    logic [LW-1:0] y0, y1, x0, x1;
    always_comb begin
        y0 = (r_r >= m) ? r_r - m : '0;
        y1 = (r_r + m < h_eff) ? r_r + m : h_eff - LW'(1);
        x0 = (r_c >= m) ? r_c - m : '0;
        x1 = (r_c + m < w_eff) ? r_c + m : w_eff - LW'(1);
    end

    // Read address: rows back from the input row wrap around the slot ring.
    logic [SW-1:0] row_back, rd_slot;
    logic [AW-1:0] rd_addr, wr_addr;
    always_comb begin
        row_back = SW'(ir - r_y);
        rd_slot  = (r_in_slot >= row_back) ? r_in_slot - row_back
                                           : SW'(r_in_slot + SW'(MAX_WINDOW) - row_back);
        rd_addr  = AW'(rd_slot) * AW'(MAX_WIDTH) + AW'(r_x);
        wr_addr  = AW'(r_in_slot) * AW'(MAX_WIDTH) + AW'(r_in_col);
    end

    logic accept, issue, seq_done;
    assign accept   = i_pix.valid && i_pix.ready;
    assign issue    = (r_state == S_SUM) && !r_iss_done;
    assign seq_done = (r_r == r_rhi) && (r_c == r_chi);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            mem[wr_addr] <= {i_pix.blue, i_pix.green, i_pix.red};
        end
        if (issue) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept && have_r && have_c) n_state = S_SETUP;
            S_SETUP: n_state = S_SUM;
            S_SUM:   if (r_iss_done && !r_rd_vld) n_state = S_DIV;
            S_DIV:   if (r_bit == BIT_W'(SUM_W - 1)) n_state = S_OUT;
            S_OUT: begin
                if (o_res.ready) n_state = seq_done ? S_IDLE : S_SETUP;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        i_pix.ready      = (r_state == S_IDLE) && !i_cfg_we;
        o_res.valid      = (r_state == S_OUT);
        o_res.out_row    = POS_W'(r_r);
        o_res.out_col    = POS_W'(r_c);
        o_res.mean_red   = r_mean[0];
        o_res.mean_green = r_mean[1];
        o_res.mean_blue  = r_mean[2];
        o_res.last       = r_last;
    end

    logic adv_pos;
    assign adv_pos = (accept && !(have_r && have_c))
                  || (r_state == S_OUT && o_res.ready && seq_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ws      <= WS_RESET;
            r_cw      <= DIM_RESET;
            r_ch      <= DIM_RESET;
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_in_slot <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_WINDOW) r_ws <= WS_W'(i_cfg_data);
                if (i_cfg_idx == CFG_WIDTH)  r_cw <= i_cfg_data;
                if (i_cfg_idx == CFG_HEIGHT) r_ch <= i_cfg_data;
                r_in_row  <= '0;
                r_in_col  <= '0;
                r_in_slot <= '0;
            end else if (adv_pos) begin
                if (ic + LW'(1) < w_eff) begin
                    r_in_col <= CW'(ic + LW'(1));
                end else begin
                    r_in_col <= '0;
                    if (ir + LW'(1) < h_eff) begin
                        r_in_row  <= RW'(ir + LW'(1));
                        r_in_slot <= (r_in_slot == SW'(MAX_WINDOW - 1)) ? '0
                                                                         : r_in_slot + 1'b1;
                    end else begin
                        r_in_row  <= '0;
                        r_in_slot <= '0;
                    end
                end
            end
        end
    end

    // Datapath: window walk, accumulation, bit-serial division.
    logic [SUM_W:0] rem_t [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rem_t[k] = {r_rem[k], r_sum[k][SUM_W-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_r   <= rlo;
                    r_rhi <= rhi;
                    r_c   <= clo;
                    r_clo <= clo;
                    r_chi <= chi;
                end
            end
            S_SETUP: begin
                r_y        <= y0;
                r_y1       <= y1;
                r_x        <= x0;
                r_x0       <= x0;
                r_x1       <= x1;
                r_cnt      <= CNT_W'((y1 - y0 + LW'(1)) * (x1 - x0 + LW'(1)));
                r_iss_done <= 1'b0;
                r_last     <= (r_r == r_rhi) && (r_c == r_chi);
                for (int k = 0; k < 3; k++) begin
                    r_sum[k] <= '0;
                end
            end
            S_SUM: begin
                if (issue) begin
                    if (r_x == r_x1) begin
                        r_x <= r_x0;
                        r_y <= r_y + LW'(1);
                        if (r_y == r_y1) r_iss_done <= 1'b1;
                    end else begin
                        r_x <= r_x + LW'(1);
                    end
                end
                if (r_rd_vld) begin
                    for (int k = 0; k < 3; k++) begin
                        r_sum[k] <= r_sum[k] + SUM_W'(r_rd_data[k*PIX_W +: PIX_W]);
                    end
                end
                r_bit <= '0;
                for (int k = 0; k < 3; k++) begin
                    r_rem[k] <= '0;
                    r_quo[k] <= '0;
                end
            end
            S_DIV: begin
                r_bit <= r_bit + 1'b1;
                for (int k = 0; k < 3; k++) begin
                    r_sum[k] <= {r_sum[k][SUM_W-2:0], 1'b0};
                    if (rem_t[k] >= (SUM_W + 1)'(r_cnt)) begin
                        r_rem[k] <= SUM_W'(rem_t[k] - (SUM_W + 1)'(r_cnt));
                        r_quo[k] <= {r_quo[k][SUM_W-2:0], 1'b1};
                    end else begin
                        r_rem[k] <= SUM_W'(rem_t[k]);
                        r_quo[k] <= {r_quo[k][SUM_W-2:0], 1'b0};
                    end
                end
            end
            S_OUT: begin
                if (o_res.ready && !seq_done) begin
                    if (r_c == r_chi) begin
                        r_c <= r_clo;
                        r_r <= r_r + LW'(1);
                    end else begin
                        r_c <= r_c + LW'(1);
                    end
                end
            end
            default: ;
        endcase
        if (r_state == S_DIV && n_state == S_OUT) begin
            for (int k = 0; k < 3; k++) begin
                if (rem_t[k] >= (SUM_W + 1)'(r_cnt)) begin
                    r_mean[k] <= ({r_quo[k][SUM_W-2:0], 1'b1} > SUM_W'(PIX_MAX)) ? PIX_MAX
                               : PIX_W'({r_quo[k][SUM_W-2:0], 1'b1});
                end else begin
                    r_mean[k] <= ({r_quo[k][SUM_W-2:0], 1'b0} > SUM_W'(PIX_MAX)) ? PIX_MAX
                               : PIX_W'({r_quo[k][SUM_W-2:0], 1'b0});
                end
            end
        end
    end

    // A memory read is only ever returned while the window is being summed.
    a_rd_in_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == S_SUM))
        else $error("row store data returned outside the summing phase");

    // The divider never sees an empty window.
    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt != '0))
        else $error("window pixel count is zero in divide");

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> (o_res.valid && $stable(o_res.mean_red)))
        else $error("result withdrawn before it was taken");

    // No pixel enters while a previous one still produces results.
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (r_state == S_IDLE && !r_rd_vld))
        else $error("pixel accepted while busy");
endmodule
`default_nettype wire

// ===== tb/tb_bmf_checker.sv =====
// Result checker for the clipped-window box mean filter: follows pixel beats and
// register writes, predicts the smoothed pixels and compares every result beat.
// Depends on bmf_pkg and the bmf_pix_if / bmf_res_if channel interfaces.
`timescale 1ns / 1ps
module tb_bmf_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_WINDOW = 15
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire [bmf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [bmf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    bmf_pix_if                             i_pix,
    bmf_res_if                             i_res,
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_checked
);
    import bmf_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             last;
    } t_mean_beat;

    t_mean_beat means_due[$];
    logic [3*PIX_W-1:0] pix_store [0:MAX_WINDOW*MAX_WIDTH-1];
    int reg_window, reg_width, reg_height;
    int pos_row, pos_col;
    int errors, checked;

    function automatic int store_slot(input int row, input int col);
        return (row % MAX_WINDOW) * MAX_WIDTH + (col % MAX_WIDTH);
    endfunction

    function automatic int clamp_dim(input int v, input int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // Stores the pixel and queues the means of every window it completes.
    task automatic predict_window_means(input logic [PIX_W-1:0] pr, pg, pb);
        int w, h, m, ir, ic, rlo, rhi, clo, chi, y0, y1, x0, x1, cnt, sr, sg, sb;
        bit have_r, have_c;
        logic [3*PIX_W-1:0] p;
        t_mean_beat e;
        w = clamp_dim(reg_width, MAX_WIDTH);
        h = clamp_dim(reg_height, MAX_HEIGHT);
        m = (reg_window == 0) ? 0 : (reg_window - 1) / 2;
        if (pos_row >= h || pos_col >= w) begin
            pos_row = 0;
            pos_col = 0;
        end
        ir = pos_row;
        ic = pos_col;
        pix_store[store_slot(ir, ic)] = {pb, pg, pr};
        if (ir == h - 1) begin
            have_r = 1;
            rlo = (ir >= m) ? ir - m : 0;
            rhi = ir;
        end else begin
            have_r = (ir >= m);
            rlo = have_r ? ir - m : 0;
            rhi = rlo;
        end
        if (ic == w - 1) begin
            have_c = 1;
            clo = (ic >= m) ? ic - m : 0;
            chi = ic;
        end else begin
            have_c = (ic >= m);
            clo = have_c ? ic - m : 0;
            chi = clo;
        end
        if (have_r && have_c) begin
            for (int rr = rlo; rr <= rhi; rr++) begin
                y0 = (rr >= m) ? rr - m : 0;
                y1 = (rr + m < h) ? rr + m : h - 1;
                for (int cc = clo; cc <= chi; cc++) begin
                    x0 = (cc >= m) ? cc - m : 0;
                    x1 = (cc + m < w) ? cc + m : w - 1;
                    sr = 0;
                    sg = 0;
                    sb = 0;
                    for (int y = y0; y <= y1; y++) begin
                        for (int x = x0; x <= x1; x++) begin
                            p = pix_store[store_slot(y, x)];
                            sr += p[7:0];
                            sg += p[15:8];
                            sb += p[23:16];
                        end
                    end
                    cnt = (y1 - y0 + 1) * (x1 - x0 + 1);
                    e.row   = rr[POS_W-1:0];
                    e.col   = cc[POS_W-1:0];
                    e.red   = (sr / cnt > 255) ? PIX_MAX : PIX_W'(sr / cnt);
                    e.green = (sg / cnt > 255) ? PIX_MAX : PIX_W'(sg / cnt);
                    e.blue  = (sb / cnt > 255) ? PIX_MAX : PIX_W'(sb / cnt);
                    e.last  = (rr == rhi && cc == chi);
                    means_due.push_back(e);
                end
            end
        end
        if (ic + 1 < w) begin
            pos_col = ic + 1;
        end else begin
            pos_col = 0;
            pos_row = (ir + 1 < h) ? ir + 1 : 0;
        end
    endtask

    always @(posedge i_clk) begin
        t_mean_beat got, want;
        if (!i_rst_n) begin
            reg_window = WS_RESET;
            reg_width  = DIM_RESET;
            reg_height = DIM_RESET;
            pos_row = 0;
            pos_col = 0;
            means_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WINDOW: reg_window = i_cfg_data[WS_W-1:0];
                    CFG_WIDTH:  reg_width  = i_cfg_data;
                    CFG_HEIGHT: reg_height = i_cfg_data;
                    default: ;
                endcase
                // Any write, known index or not, restarts the frame.
                pos_row = 0;
                pos_col = 0;
            end
            if (i_pix.valid && i_pix.ready)
                predict_window_means(i_pix.red, i_pix.green, i_pix.blue);
            if (i_res.valid && i_res.ready) begin
                got = '{i_res.out_row, i_res.out_col, i_res.mean_red, i_res.mean_green,
                        i_res.mean_blue, i_res.last};
                if (means_due.size() == 0) begin
                    errors++;
                    $display("%t: unexpected result beat row %0d col %0d rgb %0d/%0d/%0d last %0d",
                             $time, got.row, got.col, got.red, got.green, got.blue, got.last);
                end else begin
                    want = means_due.pop_front();
                    checked++;
                    if (got !== want) begin
                        errors++;
                        $display("%t: mismatch expected row %0d col %0d rgb %0d/%0d/%0d last %0d",
                                 $time, want.row, want.col, want.red, want.green, want.blue,
                                 want.last);
                        $display("%t:          actual   row %0d col %0d rgb %0d/%0d/%0d last %0d",
                                 $time, got.row, got.col, got.red, got.green, got.blue,
                                 got.last);
                    end
                end
            end
        end
        o_pending <= means_due.size();
        o_errors  <= errors;
        o_checked <= checked;
    end
endmodule

// ===== tb/tb_box_mean_filter_clipped_window_unit.sv =====
// Testbench top for the clipped-window box mean filter: drives pixel beats and
// register writes under varied idling, and gives the verdict from tb_bmf_checker.
// Depends on bmf_pkg, the channel interfaces and the block itself.
`timescale 1ns / 1ps
module tb_box_mean_filter_clipped_window_unit;
    import bmf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bmf_pix_if pix_if ();
    bmf_res_if res_if ();

    t_idle_mode idle_mode = IDLE_NONE;
    bit hold_go = 1'b0;
    bit hold_seen = 1'b0;
    int hold_cnt = 0;
    int errors, pending, checked;
    int pixels_sent, settings_used;

    always #5 i_clk = ~i_clk;

    box_mean_filter_clipped_window_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_if),
        .o_res      (res_if)
    );

    tb_bmf_checker checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_if),
        .i_res      (res_if),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_checked  (checked)
    );

    // Receiver side: a long hold-off counted here, otherwise random stalls.
    always @(posedge i_clk) begin
        if (hold_go != hold_seen) begin
            hold_seen <= hold_go;
            hold_cnt <= 400;
            res_if.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            res_if.ready <= 1'b0;
        end else if (idle_mode == IDLE_RECEIVER) begin
            res_if.ready <= ($urandom_range(99) >= 83);
        end else if (idle_mode == IDLE_BOTH) begin
            res_if.ready <= ($urandom_range(99) >= 11);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Writes all three registers on back-to-back edges.
    task automatic cfg_set(input int ws, input int w, input int h);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_WINDOW;
        i_cfg_data <= ws[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_idx <= CFG_WIDTH;
        i_cfg_data <= w[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_idx <= CFG_HEIGHT;
        i_cfg_data <= h[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Valid stays high from one beat to the next unless a gap is inserted.
    task automatic send_pixel(input logic [PIX_W-1:0] r, g, b);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SENDER) ? 83 : (idle_mode == IDLE_BOTH) ? 11 : 0;
        if ($urandom_range(99) < gap_pct) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < gap_pct) @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.red <= r;
        pix_if.green <= g;
        pix_if.blue <= b;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        pixels_sent++;
    endtask

    task automatic send_random_pixels(input int n);
        for (int k = 0; k < n; k++)
            send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
    endtask

    // Waits until every expected result has come, then lets the block settle.
    task automatic drain();
        pix_if.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        int ws, w, h, n, phase, rand_items;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_WINDOW;
        i_cfg_data = '0;
        pix_if.valid = 1'b0;
        pix_if.red = '0;
        pix_if.green = '0;
        pix_if.blue = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Window size zero on a zero-sized region: each pixel comes back as is.
        cfg_set(0, 0, 0);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'hAA, 8'h55, 8'hFF);
        drain();
        // Largest window over a tiny region: corner pixel completes all windows.
        cfg_set(15, 4, 4);
        for (int k = 0; k < 16; k++)
            send_pixel((k % 2) ? 8'd255 : 8'd0, 8'd255, 8'd0);
        drain();
        // Oversized width saturates; a single row completes every column.
        cfg_set(1, 2047, 1);
        send_random_pixels(3);
        drain();
        cfg_set(2, 3, 1024);
        send_random_pixels(4);
        drain();
        // A write to the unused index mid-frame restarts the frame.
        cfg_set(3, 4, 4);
        send_random_pixels(6);
        drain();
        cfg_write(CFG_UNUSED, 0);
        send_random_pixels(16);
        drain();
        cfg_set(0, 1024, 2047);
        send_random_pixels(3);
        drain();

        // Receiver holds off while the sender keeps offering, then a full pause.
        idle_mode = IDLE_NONE;
        cfg_set(3, 6, 4);
        hold_go <= ~hold_go;
        send_random_pixels(12);
        drain();
        send_random_pixels(12);
        drain();

        rand_items = 0;
        phase = 0;
        while (rand_items < 48 || phase < 4) begin
            idle_mode = t_idle_mode'(phase % 4);
            ws = $urandom_range(15);
            w = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(1, 4);
            h = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(1, 4);
            if (w > 4 || h > 4)
                ws = $urandom_range(3);
            n = (w <= 4 && h <= 4) ? w * h + $urandom_range(3) : $urandom_range(1, 10);
            cfg_set(ws, w, h);
            send_random_pixels(n);
            drain();
            rand_items += n;
            phase++;
        end
        idle_mode = IDLE_NONE;
        repeat (50) @(posedge i_clk);

        $display("Summary: %0d pixel beats over %0d register settings, %0d result beats compared.",
                 pixels_sent, settings_used, checked);
        if (errors == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
